// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ACSI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ACSI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/acsi_pkg.sv =====
// ----------------------------------------------------------------------------
// acsi_pkg
// Types, codes and constants of the CSI console parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acsi_pkg;

  // Result command codes
  localparam logic [2:0] CMD_CHAR  = 3'd0;
  localparam logic [2:0] CMD_NL    = 3'd1;
  localparam logic [2:0] CMD_BS    = 3'd2;
  localparam logic [2:0] CMD_MOVE  = 3'd3;
  localparam logic [2:0] CMD_CLR   = 3'd4;
  localparam logic [2:0] CMD_EOL   = 3'd5;

  // Attribute constants
  localparam logic [7:0] ATTR_DEFAULT = 8'h0F;
  localparam logic [7:0] ATTR_INVERSE = 8'h70;
  localparam logic [7:0] ATTR_BG_MASK = 8'hF0;

  // Byte codes
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_UP_H   = 8'h48;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_J   = 8'h4A;
  localparam logic [7:0] CH_UP_K   = 8'h4B;
  localparam logic [7:0] CH_LO_M   = 8'h6D;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_B   = 8'h42;
  localparam logic [7:0] CH_UP_C   = 8'h43;
  localparam logic [7:0] CH_UP_D   = 8'h44;
  localparam logic [7:0] CH_LO_H   = 8'h68;
  localparam logic [7:0] CH_LO_L   = 8'h6C;

  // SGR code ranges
  localparam int unsigned SGR_RESET   = 0;
  localparam int unsigned SGR_INVERSE = 7;
  localparam int unsigned SGR_FG_LO   = 30;
  localparam int unsigned SGR_FG_HI   = 37;
  localparam int unsigned SGR_FGB_LO  = 90;
  localparam int unsigned SGR_FGB_HI  = 97;

  // Queue operations between parser and executor
  typedef enum logic [3:0] {
    OP_CHAR,
    OP_NL,
    OP_BS,
    OP_MOVE,
    OP_CLR,
    OP_EOL,
    OP_ATTR_SET,
    OP_ATTR_FG
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [4:0] row;
    logic [6:0] col;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic walking;
    logic push;
  } front_stat_t;

  // ANSI color index to VGA foreground nibble
  function automatic logic [3:0] fg_color(input logic bright, input logic [2:0] sel);
    logic [2:0] base;
    case (sel)
      3'd0:    base = 3'h0;
      3'd1:    base = 3'h4;
      3'd2:    base = 3'h2;
      3'd3:    base = 3'h6;
      3'd4:    base = 3'h1;
      3'd5:    base = 3'h5;
      3'd6:    base = 3'h3;
      default: base = 3'h7;
    endcase
    return {bright, base};
  endfunction

endpackage

// ===== rtl/acsi_in_if.sv =====
// ----------------------------------------------------------------------------
// acsi_in_if
// Byte input channel: valid/ready handshake carrying one console byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface acsi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// ===== rtl/acsi_out_if.sv =====
// ----------------------------------------------------------------------------
// acsi_out_if
// Display command channel: valid/ready handshake carrying one command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface acsi_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] char_code;
  logic [7:0] attr;
  logic [4:0] row;
  logic [6:0] col;

  modport source (output valid, output cmd, output char_code, output attr,
                  output row, output col, input ready);
  modport sink   (input valid, input cmd, input char_code, input attr,
                  input row, input col, output ready);
endinterface

// ===== rtl/ansi_csi_text_console_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ansi_csi_text_console_parser_unit
// ANSI CSI console byte parser producing display commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one console byte per transfer (valid/ready).
//   out_chan : one display command per transfer: char, newline, backspace,
//              cursor move (clamped row/col), clear screen, clear to EOL,
//              each tagged with the text attribute current at that point.
//   The parser takes one byte per cycle while the command queue has room.
//   An SGR final ('m') then walks its 1..MAX_PARAMS parameters, one per
//   cycle while the queue has room, during which in_chan.ready is low;
//   this walk over the accumulator read port sets the worst-case rate.
//   A command byte, once accepted, is written into the queue and then into
//   the executor output register, which drives out_chan.
//   If the receiver stalls, the output register holds its command, the
//   four-entry queue fills, and then in_chan.ready drops; nothing is lost.
//   Reset (rst_n low, synchronous): parser back to normal, accumulators and
//   count cleared, attribute 0x0F, queue and output emptied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ansi_csi_text_console_parser_unit #(
  parameter int MAX_PARAMS  = 8,
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int PARAM_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  acsi_in_if.sink     in_chan,
  acsi_out_if.source  out_chan
);

  // Front (parser) -> queue -> back (executor)
  acsi_pkg::entry_t      q_wr_entry;
  acsi_pkg::entry_t      q_head;
  acsi_pkg::fifo_stat_t  q_stat;
  acsi_pkg::front_stat_t front_stat;
  logic                  q_pop;

  acsi_front #(
    .MAX_PARAMS  (MAX_PARAMS),
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .PARAM_BITS  (PARAM_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .q_entry (q_wr_entry),
    .stat    (front_stat)
  );

  // Short queue decouples the parser from a stalled receiver
  acsi_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_stat.push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_entry (q_head),
    .stat     (q_stat)
  );

  // Executor owns the attribute and the output register
  acsi_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  // Parser never writes a full queue
  `ACSI_ASSERT_IMP(a_no_push_full, front_stat.push, !q_stat.full, "push into full queue")
  // No byte is taken while an SGR walk is running
  `ACSI_ASSERT_IMP(a_no_accept_walk, in_chan.ready, !front_stat.walking, "accept during walk")
  // Only a cursor move carries a position, only a char carries a code
  `ACSI_ASSERT_IMP(a_move_fields, out_chan.valid && out_chan.cmd != acsi_pkg::CMD_MOVE,
                   out_chan.row == 5'd0 && out_chan.col == 7'd0, "stray row/col")
  `ACSI_ASSERT_IMP(a_char_field, out_chan.valid && out_chan.cmd != acsi_pkg::CMD_CHAR,
                   out_chan.char_code == 8'd0, "stray char code")

endmodule

// ===== rtl/acsi_fifo.sv =====
// ----------------------------------------------------------------------------
// acsi_fifo
// Four-entry command queue between parser and executor, head read direct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acsi_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  acsi_pkg::entry_t    wr_entry,
  input  logic                pop,
  output acsi_pkg::entry_t    rd_entry,
  output acsi_pkg::fifo_stat_t stat
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  acsi_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;

  assign stat.full  = (cnt_r == (PTR_W+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_entry   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/acsi_front.sv =====
// ----------------------------------------------------------------------------
// acsi_front
// Escape parser: tracks CSI state and parameters, queues display/attr ops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acsi_front #(
  parameter int MAX_PARAMS  = 8,
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int PARAM_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  acsi_in_if.sink               in_chan,
  input  acsi_pkg::fifo_stat_t  q_stat,
  output acsi_pkg::entry_t      q_entry,
  output acsi_pkg::front_stat_t stat
);

  localparam int IDX_W  = $clog2(MAX_PARAMS);
  localparam int CNT_W  = $clog2(MAX_PARAMS + 1);
  localparam int WIDE_W = PARAM_BITS + 4;
  localparam logic [PARAM_BITS-1:0] ROW_LIM = PARAM_BITS'(SCREEN_ROWS - 1);
  localparam logic [PARAM_BITS-1:0] COL_LIM = PARAM_BITS'(SCREEN_COLS - 1);

  typedef enum logic [1:0] {ST_NORMAL, ST_ESC, ST_CSI, ST_CSI_PARAM} pstate_t;

  pstate_t               state_r, state_nxt;
  logic [PARAM_BITS-1:0] params_r [MAX_PARAMS];
  logic [PARAM_BITS-1:0] params_nxt [MAX_PARAMS];
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  walk_r, walk_nxt;
  logic [IDX_W-1:0]      widx_r, widx_nxt;
  logic [IDX_W-1:0]      wlast_r, wlast_nxt;

  logic                  accept, push;
  logic [7:0]            ch;
  logic [IDX_W-1:0]      dig_idx, rd_idx;
  logic [PARAM_BITS-1:0] rd_val, rd_m30, rd_m90;
  logic [WIDE_W-1:0]     acc_ext, acc_wide;
  logic [PARAM_BITS-1:0] acc_sat;
  logic [CNT_W-1:0]      eff_cnt;
  logic                  sgr_has;
  acsi_pkg::entry_t      sgr_entry, entry;

  function automatic logic [PARAM_BITS-1:0] clamp_pos(input logic [PARAM_BITS-1:0] p,
                                                      input logic [PARAM_BITS-1:0] lim);
    logic [PARAM_BITS-1:0] z;
    z = (p == '0) ? '0 : p - 1'b1;
    return (z > lim) ? lim : z;
  endfunction

  assign ch       = in_chan.ch;
  assign in_chan.ready = !walk_r && !q_stat.full;
  assign accept   = in_chan.valid && in_chan.ready;

  // One shared read port on the accumulators: digit target or SGR walk
  assign dig_idx  = (cnt_r == '0) ? '0 : IDX_W'(cnt_r - 1'b1);
  assign rd_idx   = walk_r ? widx_r : dig_idx;
  assign rd_val   = params_r[rd_idx];

  // Accumulate one decimal digit, saturating
  assign acc_ext  = {4'b0, rd_val};
  assign acc_wide = (acc_ext << 3) + (acc_ext << 1) + WIDE_W'(ch[3:0]);
  assign acc_sat  = (|acc_wide[WIDE_W-1:PARAM_BITS]) ? '1 : acc_wide[PARAM_BITS-1:0];

  assign eff_cnt  = (cnt_r == '0) ? CNT_W'(1) : cnt_r;

  // SGR code decode for the parameter under the walk
  assign rd_m30 = rd_val - PARAM_BITS'(acsi_pkg::SGR_FG_LO);
  assign rd_m90 = rd_val - PARAM_BITS'(acsi_pkg::SGR_FGB_LO);

  always_comb begin
    sgr_has   = 1'b1;
    sgr_entry = '{op: acsi_pkg::OP_ATTR_SET, data: acsi_pkg::ATTR_DEFAULT,
                  row: '0, col: '0};
    if (rd_val == PARAM_BITS'(acsi_pkg::SGR_RESET)) begin
      sgr_entry.data = acsi_pkg::ATTR_DEFAULT;
    end else if (rd_val == PARAM_BITS'(acsi_pkg::SGR_INVERSE)) begin
      sgr_entry.data = acsi_pkg::ATTR_INVERSE;
    end else if (rd_val >= PARAM_BITS'(acsi_pkg::SGR_FG_LO) &&
                 rd_val <= PARAM_BITS'(acsi_pkg::SGR_FG_HI)) begin
      sgr_entry.op   = acsi_pkg::OP_ATTR_FG;
      sgr_entry.data = {4'b0, acsi_pkg::fg_color(1'b0, rd_m30[2:0])};
    end else if (rd_val >= PARAM_BITS'(acsi_pkg::SGR_FGB_LO) &&
                 rd_val <= PARAM_BITS'(acsi_pkg::SGR_FGB_HI)) begin
      sgr_entry.op   = acsi_pkg::OP_ATTR_FG;
      sgr_entry.data = {4'b0, acsi_pkg::fg_color(1'b1, rd_m90[2:0])};
    end else begin
      sgr_has = 1'b0;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    params_nxt = params_r;
    cnt_nxt    = cnt_r;
    walk_nxt   = walk_r;
    widx_nxt   = widx_r;
    wlast_nxt  = wlast_r;
    push       = 1'b0;
    entry      = '{op: acsi_pkg::OP_CHAR, data: '0, row: '0, col: '0};

    if (walk_r) begin
      if (!sgr_has || !q_stat.full) begin
        push  = sgr_has;
        entry = sgr_entry;
        if (widx_r == wlast_r) walk_nxt = 1'b0;
        else                   widx_nxt = widx_r + 1'b1;
      end
    end else if (accept) begin
      case (state_r)
        ST_NORMAL: begin
          if (ch == acsi_pkg::CH_ESC) begin
            state_nxt = ST_ESC;
          end else if (ch == acsi_pkg::CH_NL) begin
            push     = 1'b1;
            entry.op = acsi_pkg::OP_NL;
          end else if (ch >= acsi_pkg::CH_SPACE && ch <= acsi_pkg::CH_TILDE) begin
            push       = 1'b1;
            entry.op   = acsi_pkg::OP_CHAR;
            entry.data = ch;
          end else if (ch == acsi_pkg::CH_BS) begin
            push     = 1'b1;
            entry.op = acsi_pkg::OP_BS;
          end
        end
        ST_ESC: begin
          if (ch == acsi_pkg::CH_LBRACK) begin
            state_nxt = ST_CSI;
            cnt_nxt   = '0;
            for (int i = 0; i < MAX_PARAMS; i++) params_nxt[i] = '0;
          end else if (ch == acsi_pkg::CH_QMARK) begin
            state_nxt = ST_CSI;
            cnt_nxt   = '0;
          end else begin
            state_nxt = ST_NORMAL;
          end
        end
        default: begin
          if (ch >= acsi_pkg::CH_DIG0 && ch <= acsi_pkg::CH_DIG9) begin
            params_nxt[dig_idx] = acc_sat;
            if (cnt_r == '0) cnt_nxt = CNT_W'(1);
            state_nxt = ST_CSI_PARAM;
          end else if (ch == acsi_pkg::CH_SEMI) begin
            if (cnt_r < CNT_W'(MAX_PARAMS)) cnt_nxt = cnt_r + 1'b1;
            state_nxt = ST_CSI;
          end else begin
            state_nxt = ST_NORMAL;
            if (ch inside {acsi_pkg::CH_UP_H, acsi_pkg::CH_LO_F, acsi_pkg::CH_UP_J,
                           acsi_pkg::CH_UP_K, acsi_pkg::CH_LO_M, acsi_pkg::CH_UP_A,
                           acsi_pkg::CH_UP_B, acsi_pkg::CH_UP_C, acsi_pkg::CH_UP_D,
                           acsi_pkg::CH_LO_H, acsi_pkg::CH_LO_L}) begin
              // A final with no parameters stores a single zero, which only the SGR walk reads
              if (cnt_r == '0) begin
                params_nxt[0] = '0;
                cnt_nxt       = CNT_W'(1);
              end
              if (ch == acsi_pkg::CH_UP_H || ch == acsi_pkg::CH_LO_F) begin
                if (cnt_r >= CNT_W'(2)) begin
                  push      = 1'b1;
                  entry.op  = acsi_pkg::OP_MOVE;
                  entry.row = 5'(clamp_pos(params_r[0], ROW_LIM));
                  entry.col = 7'(clamp_pos(params_r[1], COL_LIM));
                end
              end else if (ch == acsi_pkg::CH_UP_J) begin
                if (cnt_r != '0 && params_r[0] == PARAM_BITS'(2)) begin
                  push     = 1'b1;
                  entry.op = acsi_pkg::OP_CLR;
                end
              end else if (ch == acsi_pkg::CH_UP_K) begin
                push     = 1'b1;
                entry.op = acsi_pkg::OP_EOL;
              end else if (ch == acsi_pkg::CH_LO_M) begin
                walk_nxt  = 1'b1;
                widx_nxt  = '0;
                wlast_nxt = IDX_W'(eff_cnt - 1'b1);
              end
            end
          end
        end
      endcase
    end
  end

  assign q_entry      = entry;
  assign stat.push    = push;
  assign stat.walking = walk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NORMAL;
      for (int i = 0; i < MAX_PARAMS; i++) params_r[i] <= '0;
      cnt_r   <= '0;
      walk_r  <= 1'b0;
      widx_r  <= '0;
      wlast_r <= '0;
    end else begin
      state_r  <= state_nxt;
      params_r <= params_nxt;
      cnt_r    <= cnt_nxt;
      walk_r   <= walk_nxt;
      widx_r   <= widx_nxt;
      wlast_r  <= wlast_nxt;
    end
  end

endmodule

// ===== rtl/acsi_back.sv =====
// ----------------------------------------------------------------------------
// acsi_back
// Executor: applies attribute ops and drives the registered command output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acsi_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acsi_pkg::fifo_stat_t q_stat,
  input  acsi_pkg::entry_t     q_head,
  output logic                 q_pop,
  acsi_out_if.source           out_chan
);

  logic [7:0] text_attr_r, text_attr_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] cmd_r, cmd_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] oattr_r, oattr_nxt;
  logic [4:0] row_r, row_nxt;
  logic [6:0] col_r, col_nxt;
  logic       is_attr_op, slot_free;

  assign is_attr_op  = (q_head.op == acsi_pkg::OP_ATTR_SET) ||
                       (q_head.op == acsi_pkg::OP_ATTR_FG);
  assign slot_free   = !out_valid_r || out_chan.ready;
  assign q_pop       = !q_stat.empty && (is_attr_op || slot_free);

  always_comb begin
    text_attr_nxt = text_attr_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    cmd_nxt       = cmd_r;
    code_nxt      = code_r;
    oattr_nxt     = oattr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    if (q_pop) begin
      case (q_head.op)
        acsi_pkg::OP_ATTR_SET: text_attr_nxt = q_head.data;
        acsi_pkg::OP_ATTR_FG:
          text_attr_nxt = (text_attr_r & acsi_pkg::ATTR_BG_MASK) | q_head.data;
        default: begin
          out_valid_nxt = 1'b1;
          oattr_nxt     = text_attr_r;
          code_nxt      = (q_head.op == acsi_pkg::OP_CHAR) ? q_head.data : 8'h00;
          row_nxt       = q_head.row;
          col_nxt       = q_head.col;
          case (q_head.op)
            acsi_pkg::OP_CHAR: cmd_nxt = acsi_pkg::CMD_CHAR;
            acsi_pkg::OP_NL:   cmd_nxt = acsi_pkg::CMD_NL;
            acsi_pkg::OP_BS:   cmd_nxt = acsi_pkg::CMD_BS;
            acsi_pkg::OP_MOVE: cmd_nxt = acsi_pkg::CMD_MOVE;
            acsi_pkg::OP_CLR:  cmd_nxt = acsi_pkg::CMD_CLR;
            default:           cmd_nxt = acsi_pkg::CMD_EOL;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= acsi_pkg::ATTR_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      text_attr_r <= text_attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    code_r  <= code_nxt;
    oattr_r <= oattr_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.cmd       = cmd_r;
  assign out_chan.char_code = code_r;
  assign out_chan.attr      = oattr_r;
  assign out_chan.row       = row_r;
  assign out_chan.col       = col_r;

endmodule
